// File: rtl/core/pek_pkg.sv
// Shared types, constants and helpers of the power-exponential correlation kernel.
package pek_pkg;

  localparam int MAX_DIMS = 4;
  localparam int LANE_LAT = 72;
  localparam int PIPE_LEN = LANE_LAT + MAX_DIMS + 1;

  typedef logic [30:0] q30_t;

  localparam q30_t ONE_Q30 = 31'h40000000;

  localparam q30_t EXP2_TAB [16] = '{
    31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436,
    31'd1097251708, 31'd1085434106, 31'd1079572136, 31'd1076653033,
    31'd1075196443, 31'd1074468888, 31'd1074105294, 31'd1073923544,
    31'd1073832680, 31'd1073787251, 31'd1073764537, 31'd1073753181
  };

  typedef enum logic [2:0] {
    REG_ALPHA   = 3'd0,
    REG_VAR     = 3'd1,
    REG_NUGGET  = 3'd2,
    REG_RHO0    = 3'd3,
    REG_RHO1    = 3'd4,
    REG_RHO2    = 3'd5,
    REG_RHO3    = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic one;
    logic kill;
  } lane_ctl_t;

  function automatic logic [4:0] top_bit(input logic [31:0] x);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) n = 5'(i);
    end
    return n;
  endfunction

endpackage

// File: rtl/core/pek_log2_cell.sv
// One squaring step of the log2 fraction chain.
module pek_log2_cell (
  input  logic          clk_i,
  input  pek_pkg::q30_t m_i,
  input  logic [15:0]   frac_i,
  output pek_pkg::q30_t m_o,
  output logic [15:0]   frac_o
);
  import pek_pkg::*;

  logic [61:0] sq;
  q30_t        m_d, m_q;
  logic        bit_d;
  logic [15:0] frac_q;

  assign sq = 62'(m_i) * 62'(m_i);

  always_comb begin
    if (sq[61]) begin
      m_d   = sq[61:31];
      bit_d = 1'b1;
    end else begin
      m_d   = sq[60:30];
      bit_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    frac_q <= {frac_i[14:0], bit_d};
  end

  assign m_o    = m_q;
  assign frac_o = frac_q;

endmodule

// File: rtl/core/pek_exp2_cell.sv
// One conditional multiply step of the exp2 fraction chain.
module pek_exp2_cell (
  input  logic          clk_i,
  input  pek_pkg::q30_t r_i,
  input  logic [15:0]   f_i,
  input  pek_pkg::q30_t coef_i,
  output pek_pkg::q30_t r_o,
  output logic [15:0]   f_o
);
  import pek_pkg::*;

  logic [61:0] pr;
  q30_t        r_q;
  logic [15:0] f_q;

  assign pr = 62'(r_i) * 62'(coef_i);

  always_ff @(posedge clk_i) begin
    r_q <= f_i[15] ? pr[60:30] : r_i;
    f_q <= {f_i[14:0], 1'b0};
  end

  assign r_o = r_q;
  assign f_o = f_q;

endmodule

// File: rtl/core/pek_lane.sv
// Per-dimension pipeline computing rho^(4*d^alpha) in Q.30.
module pek_lane (
  input  logic          clk_i,
  input  logic [31:0]   dist_i,
  input  logic [16:0]   rho_i,
  input  logic [15:0]   alpha_i,
  output pek_pkg::q30_t factor_o
);
  import pek_pkg::*;

  logic [31:0] dist_q;
  logic [15:0] rho_q;
  logic [4:0]  nd_q;
  logic [3:0]  nr_q;
  lane_ctl_t   ca_q;
  logic [4:0]  nr_full;

  assign nr_full = top_bit({16'b0, rho_i[15:0]});

  always_ff @(posedge clk_i) begin
    dist_q  <= dist_i;
    rho_q   <= rho_i[15:0];
    nd_q    <= top_bit(dist_i);
    nr_q    <= nr_full[3:0];
    ca_q.one  <= (dist_i == '0) | rho_i[16];
    ca_q.kill <= (rho_i == '0);
  end

  logic [61:0] dsh;
  logic [45:0] rsh;
  q30_t        mdb_q, mrb_q;

  assign dsh = {dist_q, 30'b0} >> nd_q;
  assign rsh = {rho_q, 30'b0} >> nr_q;

  q30_t        md [17];
  logic [15:0] fd [17];
  q30_t        mr [17];
  logic [15:0] fr [17];
  logic [4:0]  nd_s_q [17];
  logic [3:0]  nr_s_q [17];
  lane_ctl_t   c1_q [17];

  always_ff @(posedge clk_i) begin
    mdb_q     <= dsh[30:0];
    mrb_q     <= rsh[30:0];
    nd_s_q[0] <= nd_q;
    nr_s_q[0] <= nr_q;
    c1_q[0]   <= ca_q;
  end

  assign md[0] = mdb_q;
  assign fd[0] = '0;
  assign mr[0] = mrb_q;
  assign fr[0] = '0;

  for (genvar k = 0; k < 16; k++) begin : g_log_a
    pek_log2_cell u_cell_d (
      .clk_i  (clk_i),
      .m_i    (md[k]),
      .frac_i (fd[k]),
      .m_o    (md[k+1]),
      .frac_o (fd[k+1])
    );
    pek_log2_cell u_cell_r (
      .clk_i  (clk_i),
      .m_i    (mr[k]),
      .frac_i (fr[k]),
      .m_o    (mr[k+1]),
      .frac_o (fr[k+1])
    );
    always_ff @(posedge clk_i) begin
      nd_s_q[k+1] <= nd_s_q[k];
      nr_s_q[k+1] <= nr_s_q[k];
      c1_q[k+1]   <= c1_q[k];
    end
  end

  logic signed [21:0] ld_off;
  logic signed [38:0] tprod_q;
  logic [20:0]        lr_q;
  lane_ctl_t          ct_q;

  assign ld_off = $signed({1'b0, nd_s_q[16], fd[16]}) - 22'sh100000;

  always_ff @(posedge clk_i) begin
    tprod_q <= 39'(ld_off) * 39'($signed({1'b0, alpha_i}));
    lr_q    <= 21'h100000 - {1'b0, nr_s_q[16], fr[16]};
    ct_q    <= c1_q[16];
  end

  logic signed [38:0] tadj;
  logic signed [38:0] tsh;
  logic signed [24:0] s_q;
  logic [4:0]         nl_q;
  logic [20:0]        lrs_q;
  lane_ctl_t          cs_q;

  assign tadj = tprod_q[38] ? tprod_q + 39'sd16383 : tprod_q;
  assign tsh  = tadj >>> 14;

  always_ff @(posedge clk_i) begin
    s_q   <= 25'(tsh) + 25'sh20000;
    nl_q  <= top_bit({11'b0, lr_q});
    lrs_q <= lr_q;
    cs_q  <= ct_q;
  end

  logic [50:0] lsh;
  q30_t        mlb_q;

  assign lsh = {lrs_q, 30'b0} >> nl_q;

  q30_t               ml [17];
  logic [15:0]        fl [17];
  logic signed [24:0] s_s_q [17];
  logic [4:0]         nl_s_q [17];
  lane_ctl_t          c2_q [17];

  always_ff @(posedge clk_i) begin
    mlb_q     <= lsh[30:0];
    s_s_q[0]  <= s_q;
    nl_s_q[0] <= nl_q;
    c2_q[0]   <= cs_q;
  end

  assign ml[0] = mlb_q;
  assign fl[0] = '0;

  for (genvar k = 0; k < 16; k++) begin : g_log_b
    pek_log2_cell u_cell_l (
      .clk_i  (clk_i),
      .m_i    (ml[k]),
      .frac_i (fl[k]),
      .m_o    (ml[k+1]),
      .frac_o (fl[k+1])
    );
    always_ff @(posedge clk_i) begin
      s_s_q[k+1]  <= s_s_q[k];
      nl_s_q[k+1] <= nl_s_q[k];
      c2_q[k+1]   <= c2_q[k];
    end
  end

  logic signed [25:0] v;
  logic               big;
  logic [15:0]        fv_q;

  assign v   = 26'(s_s_q[16]) + $signed({5'b0, nl_s_q[16], fl[16]});
  assign big = (v >= 26'sd1376256);

  q30_t        r3 [17];
  logic [15:0] f3 [17];
  logic [4:0]  n3_s_q [17];
  logic        neg_s_q [17];
  lane_ctl_t   c3_q [17];

  always_ff @(posedge clk_i) begin
    fv_q         <= v[15:0];
    n3_s_q[0]    <= v[20:16];
    neg_s_q[0]   <= v[25];
    c3_q[0].one  <= c2_q[16].one;
    c3_q[0].kill <= c2_q[16].kill | big;
  end

  assign r3[0] = ONE_Q30;
  assign f3[0] = fv_q;

  for (genvar k = 0; k < 16; k++) begin : g_exp_a
    pek_exp2_cell u_cell_e (
      .clk_i  (clk_i),
      .r_i    (r3[k]),
      .f_i    (f3[k]),
      .coef_i (EXP2_TAB[k]),
      .r_o    (r3[k+1]),
      .f_o    (f3[k+1])
    );
    always_ff @(posedge clk_i) begin
      n3_s_q[k+1]  <= n3_s_q[k];
      neg_s_q[k+1] <= neg_s_q[k];
      c3_q[k+1]    <= c3_q[k];
    end
  end

  logic [4:0]  gsh;
  q30_t        g;
  logic [15:0] fin_q;

  assign gsh = 5'd30 - n3_s_q[16];
  assign g   = neg_s_q[16] ? '0 : (r3[16] >> gsh);

  q30_t        r4 [17];
  logic [15:0] f4 [17];
  logic [5:0]  sh_s_q [17];
  lane_ctl_t   c4_q [17];

  always_ff @(posedge clk_i) begin
    fin_q     <= 16'h0 - g[15:0];
    sh_s_q[0] <= {1'b0, g[20:16]} + 6'(g[15:0] != '0);
    c4_q[0]   <= c3_q[16];
  end

  assign r4[0] = ONE_Q30;
  assign f4[0] = fin_q;

  for (genvar k = 0; k < 16; k++) begin : g_exp_b
    pek_exp2_cell u_cell_e (
      .clk_i  (clk_i),
      .r_i    (r4[k]),
      .f_i    (f4[k]),
      .coef_i (EXP2_TAB[k]),
      .r_o    (r4[k+1]),
      .f_o    (f4[k+1])
    );
    always_ff @(posedge clk_i) begin
      sh_s_q[k+1] <= sh_s_q[k];
      c4_q[k+1]   <= c4_q[k];
    end
  end

  q30_t factor_q;

  always_ff @(posedge clk_i) begin
    if (c4_q[16].one) begin
      factor_q <= ONE_Q30;
    end else if (c4_q[16].kill) begin
      factor_q <= '0;
    end else begin
      factor_q <= r4[16] >> sh_s_q[16];
    end
  end

  assign factor_o = factor_q;

endmodule

// File: rtl/core/power_exp_correlation_kernel.sv
// Top level of the power-exponential correlation kernel: registers, lanes, product chain.
//
//  channel   direction  signals                                   transfer when
//  command   in         start, busy, point_a_x*_i, point_b_x*_i,   start & !busy
//                       is_diagonal_i
//  result    out        done_o, corr_value_o                       done_o
//  config    in/out     psel, penable, pwrite, paddr, pwdata,      psel & penable & pwrite
//                       prdata, pready
//
// One item per cycle; busy stays low. Each result passes through four log2/exp2 cell chains
// of 16 cells each in every dimension lane, then one product stage per dimension and the
// variance multiply. Reset clears the valid line and sets the configuration registers to
// their defaults, not the data path; results cannot be held off.
module power_exp_correlation_kernel (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] point_a_x0_i,
  input  logic [31:0] point_a_x1_i,
  input  logic [31:0] point_a_x2_i,
  input  logic [31:0] point_a_x3_i,
  input  logic [31:0] point_b_x0_i,
  input  logic [31:0] point_b_x1_i,
  input  logic [31:0] point_b_x2_i,
  input  logic [31:0] point_b_x3_i,
  input  logic        is_diagonal_i,
  output logic        done_o,
  output logic [31:0] corr_value_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pek_pkg::*;

  logic [15:0] alpha_q;
  logic [31:0] var_q;
  logic [31:0] nug_q;
  logic [16:0] rho_q [4];
  logic        wr;
  cfg_reg_e    idx;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr     = psel & penable & pwrite & pready;
  assign idx    = cfg_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= 16'd16384;
      var_q    <= 32'd65536;
      nug_q    <= '0;
      rho_q[0] <= 17'd65536;
      rho_q[1] <= 17'd65536;
      rho_q[2] <= 17'd65536;
      rho_q[3] <= 17'd65536;
    end else if (wr) begin
      case (idx)
        REG_ALPHA:  alpha_q  <= pwdata[15:0];
        REG_VAR:    var_q    <= pwdata;
        REG_NUGGET: nug_q    <= pwdata;
        REG_RHO0:   rho_q[0] <= pwdata[16:0];
        REG_RHO1:   rho_q[1] <= pwdata[16:0];
        REG_RHO2:   rho_q[2] <= pwdata[16:0];
        REG_RHO3:   rho_q[3] <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ALPHA:  prdata = {16'b0, alpha_q};
      REG_VAR:    prdata = var_q;
      REG_NUGGET: prdata = nug_q;
      REG_RHO0:   prdata = {15'b0, rho_q[0]};
      REG_RHO1:   prdata = {15'b0, rho_q[1]};
      REG_RHO2:   prdata = {15'b0, rho_q[2]};
      REG_RHO3:   prdata = {15'b0, rho_q[3]};
      default:    prdata = '0;
    endcase
  end

  logic [31:0] pa [4];
  logic [31:0] pb [4];

  assign pa[0] = point_a_x0_i;
  assign pa[1] = point_a_x1_i;
  assign pa[2] = point_a_x2_i;
  assign pa[3] = point_a_x3_i;
  assign pb[0] = point_b_x0_i;
  assign pb[1] = point_b_x1_i;
  assign pb[2] = point_b_x2_i;
  assign pb[3] = point_b_x3_i;

  logic acc;
  logic vld_q  [PIPE_LEN];
  logic diag_q [PIPE_LEN];

  assign acc = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PIPE_LEN; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= acc;
      for (int i = 1; i < PIPE_LEN; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    diag_q[0] <= is_diagonal_i;
    for (int i = 1; i < PIPE_LEN; i++) diag_q[i] <= diag_q[i-1];
  end

  q30_t fac  [MAX_DIMS];
  q30_t fsel [MAX_DIMS];
  q30_t pq_q [MAX_DIMS];

  for (genvar k = 0; k < MAX_DIMS; k++) begin : g_dim
    logic signed [32:0] diff;
    logic [32:0]        adiff;
    logic [31:0]        dist_q;
    logic [61:0]        pm;

    assign diff  = 33'($signed(pa[k])) - 33'($signed(pb[k]));
    assign adiff = diff[32] ? 33'(-diff) : 33'(diff);

    always_ff @(posedge clk_i) begin
      dist_q <= adiff[31:0];
    end

    pek_lane u_lane (
      .clk_i    (clk_i),
      .dist_i   (dist_q),
      .rho_i    (rho_q[k]),
      .alpha_i  (alpha_q),
      .factor_o (fac[k])
    );

    if (k == 0) begin : g_nodly
      assign fsel[k] = fac[k];
      assign pm      = 62'(ONE_Q30) * 62'(fsel[k]);
    end else begin : g_dly
      q30_t dly_q [k];
      always_ff @(posedge clk_i) begin
        dly_q[0] <= fac[k];
        for (int j = 1; j < k; j++) dly_q[j] <= dly_q[j-1];
      end
      assign fsel[k] = dly_q[k-1];
      assign pm      = 62'(pq_q[k-1]) * 62'(fsel[k]);
    end

    always_ff @(posedge clk_i) begin
      pq_q[k] <= pm[60:30];
    end
  end

  logic [63:0] vm;
  logic [32:0] dsum;
  logic        done_q;
  logic [31:0] corr_q;

  assign vm   = 64'(var_q) * 64'(pq_q[MAX_DIMS-1]);
  assign dsum = {1'b0, var_q} + {1'b0, nug_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[PIPE_LEN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (diag_q[PIPE_LEN-1]) begin
      corr_q <= dsum[32] ? 32'hFFFFFFFF : dsum[31:0];
    end else begin
      corr_q <= vm[61:30];
    end
  end

  assign done_o       = done_q;
  assign corr_value_o = corr_q;

endmodule

// File: verif/power_exp_correlation_kernel_tb.sv
// Self-checking testbench of the power-exponential correlation kernel with its own predictor.
module power_exp_correlation_kernel_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pek_pkg::*;

  localparam int WATCH_LIMIT = 2000;
  localparam int DRAIN = PIPE_LEN + 8;
  localparam int N_PHASES = 8;
  localparam int PHASE_ITEMS = 250;

  class kernel_scoreboard;
    bit [15:0] alpha = 16'd16384;
    bit [31:0] sigma2 = 32'd65536;
    bit [31:0] nugget = 32'd0;
    bit [16:0] rho [4] = '{17'd65536, 17'd65536, 17'd65536, 17'd65536};
    bit [31:0] pending [$];
    int errors = 0;
    int shown = 0;

    function void set_reg(cfg_reg_e r, bit [31:0] v);
      case (r)
        REG_ALPHA:  alpha = v[15:0];
        REG_VAR:    sigma2 = v;
        REG_NUGGET: nugget = v;
        REG_RHO0:   rho[0] = v[16:0];
        REG_RHO1:   rho[1] = v[16:0];
        REG_RHO2:   rho[2] = v[16:0];
        REG_RHO3:   rho[3] = v[16:0];
        default: ;
      endcase
    endfunction

    function longint log2_fix(bit [31:0] x);
      int n;
      longint unsigned m;
      longint frac;
      n = 31;
      frac = 0;
      if (x == 0) return 0;
      while (n > 0 && !x[n]) n--;
      m = ({32'b0, x} << 30) >> n;
      for (int i = 15; i >= 0; i--) begin
        m = (m * m) >> 30;
        if (m >= (64'd1 << 31)) begin
          m = m >> 1;
          frac = frac | (longint'(1) << i);
        end
      end
      return longint'(n) * 65536 + frac;
    endfunction

    function longint unsigned pow2_frac(bit [15:0] f);
      longint unsigned r;
      r = 64'd1 << 30;
      for (int j = 0; j < 16; j++) begin
        if (f[15-j]) r = (r * longint'(EXP2_TAB[j])) >> 30;
      end
      return r;
    endfunction

    function longint unsigned dim_corr(bit [31:0] d, bit [16:0] base);
      longint t, lr, u, v;
      longint unsigned g, n;
      bit [15:0] f;
      if (d == 0 || base >= 17'd65536) return 64'd1 << 30;
      if (base == 0) return 0;
      t = ((log2_fix(d) - 16 * 65536) * longint'(alpha)) / 16384;
      lr = 16 * 65536 - log2_fix({15'b0, base});
      u = t + 2 * 65536 + log2_fix(lr[31:0]) - 16 * 65536;
      if (u >= 5 * 65536) return 0;
      v = u + 16 * 65536;
      if (v < 0) g = 0;
      else g = pow2_frac(v[15:0]) >> (30 - (v >>> 16));
      if (g >= (64'd32 << 16)) return 0;
      n = g >> 16;
      f = g[15:0];
      if (f == 0) return (64'd1 << 30) >> n;
      return pow2_frac(16'(17'h10000 - f)) >> (n + 1);
    endfunction

    function void note(bit [3:0][31:0] a, bit [3:0][31:0] b, bit diag);
      longint unsigned prod, sum;
      longint diff;
      if (diag) begin
        sum = longint'(sigma2) + longint'(nugget);
        pending.push_back(sum > 64'hFFFFFFFF ? 32'hFFFFFFFF : sum[31:0]);
      end else begin
        prod = 64'd1 << 30;
        for (int k = 0; k < MAX_DIMS; k++) begin
          diff = longint'($signed(a[k])) - longint'($signed(b[k]));
          if (diff < 0) diff = -diff;
          prod = (prod * dim_corr(diff[31:0], rho[k])) >> 30;
        end
        prod = (longint'(sigma2) * prod) >> 30;
        pending.push_back(prod[31:0]);
      end
    endfunction

    function void check(bit [31:0] got);
      bit [31:0] want;
      if (pending.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected corr_value %h", got);
        end
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("corr_value mismatch: expected %h actual %h", want, got);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0][31:0] pa = '0;
  logic [3:0][31:0] pb = '0;
  logic        is_diagonal_i = 1'b0;
  logic        done_o;
  logic [31:0] corr_value_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  kernel_scoreboard sb = new();
  int idle_pct = 0;
  int quiet = 0;

  power_exp_correlation_kernel dut (
    .clk_i, .rst_ni, .start, .busy,
    .point_a_x0_i(pa[0]), .point_a_x1_i(pa[1]), .point_a_x2_i(pa[2]), .point_a_x3_i(pa[3]),
    .point_b_x0_i(pb[0]), .point_b_x1_i(pb[1]), .point_b_x2_i(pb[2]), .point_b_x3_i(pb[3]),
    .is_diagonal_i, .done_o, .corr_value_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        sb.check(corr_value_o);
      end
      if (start && !busy) begin
        sb.note(pa, pb, is_diagonal_i);
      end
      if (done_o || (start && !busy)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (quiet >= WATCH_LIMIT) begin
        $display("power_exp_correlation_kernel_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_reg_e r, bit [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(r, v);
  endtask

  task automatic wait_idle();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic send(bit [3:0][31:0] a, bit [3:0][31:0] b, bit diag);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    pa <= a;
    pb <= b;
    is_diagonal_i <= diag;
    do @(posedge clk_i); while (busy);
  endtask

  function automatic bit [16:0] pick_rho();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'($urandom_range(65536, 131071));
      3: return 17'($urandom_range(1, 255));
      default: return 17'($urandom_range(40000, 65535));
    endcase
  endfunction

  task automatic send_random();
    bit [3:0][31:0] a, b;
    bit [31:0] delta;
    for (int k = 0; k < 4; k++) begin
      a[k] = $urandom;
      delta = $urandom >> $urandom_range(8, 31);
      case ($urandom_range(0, 9))
        0: b[k] = a[k];
        1: b[k] = $urandom;
        2: b[k] = a[k] - delta;
        default: b[k] = a[k] + delta;
      endcase
    end
    send(a, b, $urandom_range(0, 9) == 0);
  endtask

  initial begin
    bit [3:0][31:0] z, mx, mn, one;
    z = '0;
    mx = {4{32'h7FFFFFFF}};
    mn = {4{32'h80000000}};
    one = {4{32'h00000001}};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(z, z, 1'b0);
    send(z, z, 1'b1);
    send(mx, mn, 1'b0);
    send(mn, mx, 1'b0);
    send(one, z, 1'b0);
    send({4{32'h00010000}}, z, 1'b0);
    start <= 1'b0;
    wait_idle();
    write_reg(REG_ALPHA, 32'd16384);
    write_reg(REG_VAR, 32'hFFFFFFFF);
    write_reg(REG_NUGGET, 32'hFFFFFFFF);
    write_reg(REG_RHO0, 32'd0);
    write_reg(REG_RHO1, 32'd1);
    write_reg(REG_RHO2, 32'd65535);
    write_reg(REG_RHO3, 32'h1FFFF);
    send(z, z, 1'b1);
    send(z, z, 1'b0);
    send(one, z, 1'b0);
    send(z, one, 1'b0);
    send({4{32'h00000100}}, z, 1'b0);
    send({4{32'h00010000}}, z, 1'b0);
    send({32'h00000001, 32'h00000001, 32'h0, 32'h0}, z, 1'b0);
    send(mx, mn, 1'b0);
    send({32'h0, 32'h0, 32'h0, 32'hFFFFFFFF}, z, 1'b0);
    send({32'h0, 32'h0, 32'h00000040, 32'h0}, z, 1'b0);
    start <= 1'b0;

    for (int p = 0; p < N_PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin
          write_reg(REG_ALPHA, 32'd1);
          write_reg(REG_VAR, 32'hFFFFFFFF);
          write_reg(REG_NUGGET, 32'd0);
        end
        1: begin
          write_reg(REG_ALPHA, 32'd32768);
          write_reg(REG_VAR, 32'd0);
          write_reg(REG_NUGGET, 32'd1);
        end
        2: begin
          write_reg(REG_ALPHA, 32'd0);
          write_reg(REG_VAR, 32'd65536);
          write_reg(REG_NUGGET, 32'd0);
        end
        default: begin
          write_reg(REG_ALPHA, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                             : $urandom_range(1, 32768));
          write_reg(REG_VAR, ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 262144));
          write_reg(REG_NUGGET, $urandom);
        end
      endcase
      write_reg(REG_RHO0, 32'(pick_rho()));
      write_reg(REG_RHO1, 32'(pick_rho()));
      write_reg(REG_RHO2, 32'(pick_rho()));
      write_reg(REG_RHO3, 32'(pick_rho()));
      idle_pct = (p < 3) ? 37 : (p < 6) ? 82 : 0;
      for (int i = 0; i < PHASE_ITEMS; i++) send_random();
      start <= 1'b0;
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("power_exp_correlation_kernel_tb OK");
    end else begin
      $display("power_exp_correlation_kernel_tb NOT OK");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/core/pek_pkg.sv
rtl/core/pek_log2_cell.sv
rtl/core/pek_exp2_cell.sv
rtl/core/pek_lane.sv
rtl/core/power_exp_correlation_kernel.sv
verif/power_exp_correlation_kernel_tb.sv
